@@ hdl/epoch_seconds_to_calendar_date_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared property forms for the date converter checks
// ---------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_MACROS_SVH

// same-cycle implication
`define ESC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ESC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/esc_pkg.sv @@
// ---------------------------------------------------------------------------
// esc_pkg
// types, constants and month table for the epoch to calendar converter
// ---------------------------------------------------------------------------
package esc_pkg;

   localparam int SECS_W = 31;
   localparam int DAYS_W = 15;
   localparam int TOD_W  = 17;
   localparam int REMH_W = 12;
   localparam int WQ_W   = 12;

   // constant divisions by reciprocal multiply: q = ((x >> PRE) * MUL) >> QSH
   // 86400 = 675 << 7, exact for every 24-bit x
   localparam int          DAY_PRE  = 7;
   localparam logic [24:0] DAY_MUL  = 25'd25451659;
   localparam int          DAY_QSH  = 34;
   // 3600 = 225 << 4, exact below one day
   localparam int          HOUR_PRE = 4;
   localparam logic [13:0] HOUR_MUL = 14'd9321;
   localparam int          HOUR_QSH = 21;
   // 60 = 15 << 2, exact below one hour
   localparam int          MIN_PRE  = 2;
   localparam logic [10:0] MIN_MUL  = 11'd1093;
   localparam int          MIN_QSH  = 14;
   // divide by 7, exact for every 15-bit day count
   localparam logic [15:0] WDAY_MUL = 16'd37450;
   localparam int          WDAY_QSH = 18;

   localparam logic [16:0] DAY_SECS  = 17'd86400;
   localparam logic [11:0] HOUR_SECS = 12'd3600;
   localparam logic [5:0]  MIN_SECS  = 6'd60;
   localparam logic [2:0]  WEEK_DAYS = 3'd7;

   localparam logic [10:0] FIRST_YEAR   = 11'd1970;
   localparam logic [6:0]  FIRST_C100   = 7'd70;
   localparam logic [8:0]  FIRST_C400   = 9'd370;
   localparam logic [2:0]  THURSDAY     = 3'd4;
   localparam logic [8:0]  DAYS_NORMAL  = 9'd365;
   localparam logic [8:0]  DAYS_LEAP    = 9'd366;
   localparam logic [3:0]  LAST_MONTH   = 4'd11;

   // datapath load codes
   localparam logic [3:0] LD_NONE  = 4'd0;
   localparam logic [3:0] LD_SECS  = 4'd1;
   localparam logic [3:0] LD_DAYS  = 4'd2;
   localparam logic [3:0] LD_TOD   = 4'd3;
   localparam logic [3:0] LD_HOUR  = 4'd4;
   localparam logic [3:0] LD_REMH  = 4'd5;
   localparam logic [3:0] LD_MIN   = 4'd6;
   localparam logic [3:0] LD_SEC   = 4'd7;
   localparam logic [3:0] LD_MONTH = 4'd8;

   typedef struct packed {
      logic [3:0] load;
      logic       year_step;
      logic       month_step;
      logic       out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic year_fit;
      logic month_fit;
   } dp_sts_type;

   function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
      logic [4:0] len;
      unique case (mon)
         4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
         4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
         4'd1:                                      len = leap ? 5'd29 : 5'd28;
         default:                                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

@@ hdl/esc_dpath.sv @@
// ---------------------------------------------------------------------------
// esc_dpath
// reciprocal-multiply time split, year and month walkers, result register
// ---------------------------------------------------------------------------
`include "epoch_seconds_to_calendar_date_macros.svh"

module esc_dpath
   import esc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_sts_type          sts,
   input  logic [SECS_W-1:0]   req_epoch_seconds,
   output logic [10:0]         rsp_year,
   output logic [3:0]          rsp_month,
   output logic [4:0]          rsp_day_of_month,
   output logic [4:0]          rsp_hour,
   output logic [5:0]          rsp_minute,
   output logic [5:0]          rsp_second,
   output logic [2:0]          rsp_weekday
);

   logic [SECS_W-1:0] secs_ff;
   logic [DAYS_W-1:0] days_ff;
   logic [TOD_W-1:0]  tod_ff;
   logic [REMH_W-1:0] remh_ff;
   logic [WQ_W-1:0]   wq_ff;
   logic [4:0]        hour_ff;
   logic [5:0]        minute_ff, second_ff;
   logic [2:0]        weekday_ff;
   logic [10:0]       year_ff;
   logic [6:0]        c100_ff;
   logic [8:0]        c400_ff;
   logic [3:0]        mon_ff;

   logic [10:0] out_year_ff;
   logic [3:0]  out_month_ff;
   logic [4:0]  out_mday_ff, out_hour_ff;
   logic [5:0]  out_minute_ff, out_second_ff;
   logic [2:0]  out_wday_ff;

   logic [48:0]       day_prod;
   logic [SECS_W-1:0] day_base;
   logic [DAYS_W-1:0] wday_num, wday_base;
   logic [29:0]       wday_prod;
   logic [25:0]       hour_prod;
   logic [TOD_W-1:0]  hour_base;
   logic [19:0]       min_prod;
   logic [REMH_W-1:0] min_base;

   logic        leap;
   logic [8:0]  ylen;
   logic [4:0]  mlen;

   // quotients by reciprocal multiply, remainders by multiply back and subtract
   assign day_prod  = 49'(secs_ff[SECS_W-1:DAY_PRE]) * 49'(DAY_MUL);
   assign day_base  = SECS_W'(days_ff) * SECS_W'(DAY_SECS);
   assign wday_num  = days_ff + DAYS_W'(THURSDAY);
   assign wday_prod = 30'(wday_num) * 30'(WDAY_MUL);
   assign wday_base = DAYS_W'(wq_ff) * DAYS_W'(WEEK_DAYS);
   assign hour_prod = 26'(tod_ff[TOD_W-1:HOUR_PRE]) * 26'(HOUR_MUL);
   assign hour_base = TOD_W'(hour_ff) * TOD_W'(HOUR_SECS);
   assign min_prod  = 20'(remh_ff[REMH_W-1:MIN_PRE]) * 20'(MIN_MUL);
   assign min_base  = REMH_W'(minute_ff) * REMH_W'(MIN_SECS);

   assign leap = (year_ff[1:0] == 2'b00) && ((c100_ff != 7'd0) || (c400_ff == 9'd0));
   assign ylen = leap ? DAYS_LEAP : DAYS_NORMAL;
   assign mlen = month_len(leap, mon_ff);

   assign sts.year_fit  = (days_ff < DAYS_W'(ylen));
   assign sts.month_fit = (mon_ff == LAST_MONTH) || (days_ff < DAYS_W'(mlen));

   // split and walk registers
   always_ff @(posedge clock) begin
      unique case (cmd.load)
         LD_SECS: begin
            secs_ff <= req_epoch_seconds;
         end
         LD_DAYS: begin
            days_ff <= DAYS_W'(day_prod >> DAY_QSH);
         end
         LD_TOD: begin
            tod_ff <= TOD_W'(secs_ff - day_base);
            wq_ff  <= WQ_W'(wday_prod >> WDAY_QSH);
         end
         LD_HOUR: begin
            hour_ff    <= 5'(hour_prod >> HOUR_QSH);
            weekday_ff <= 3'(wday_num - wday_base);
         end
         LD_REMH: begin
            remh_ff <= REMH_W'(tod_ff - hour_base);
         end
         LD_MIN: begin
            minute_ff <= 6'(min_prod >> MIN_QSH);
         end
         LD_SEC: begin
            second_ff <= 6'(remh_ff - min_base);
            year_ff   <= FIRST_YEAR;
            c100_ff   <= FIRST_C100;
            c400_ff   <= FIRST_C400;
         end
         LD_MONTH: begin
            mon_ff <= '0;
         end
         default: begin
            if (cmd.year_step) begin
               days_ff <= days_ff - DAYS_W'(ylen);
               year_ff <= year_ff + 11'd1;
               c100_ff <= (c100_ff == 7'd99)  ? 7'd0 : c100_ff + 7'd1;
               c400_ff <= (c400_ff == 9'd399) ? 9'd0 : c400_ff + 9'd1;
            end
            if (cmd.month_step) begin
               days_ff <= days_ff - DAYS_W'(mlen);
               mon_ff  <= mon_ff + 4'd1;
            end
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_year_ff   <= year_ff;
         out_month_ff  <= mon_ff;
         out_mday_ff   <= days_ff[4:0] + 5'd1;
         out_hour_ff   <= hour_ff;
         out_minute_ff <= minute_ff;
         out_second_ff <= second_ff;
         out_wday_ff   <= weekday_ff;
      end
   end

   assign rsp_year         = out_year_ff;
   assign rsp_month        = out_month_ff;
   assign rsp_day_of_month = out_mday_ff;
   assign rsp_hour         = out_hour_ff;
   assign rsp_minute       = out_minute_ff;
   assign rsp_second       = out_second_ff;
   assign rsp_weekday      = out_wday_ff;

   `ESC_ASSERT_IMP(a_month_bound, clock, reset, cmd.month_step, mon_ff != LAST_MONTH, "month overrun")
   `ESC_ASSERT_NXT(a_year_inc, clock, reset, cmd.year_step, year_ff == $past(year_ff) + 11'd1, "year stuck")
   `ESC_ASSERT_IMP(a_hour_range, clock, reset, cmd.out_load, hour_ff <= 5'd23, "hour out of range")

endmodule

@@ hdl/esc_ctrl.sv @@
// ---------------------------------------------------------------------------
// esc_ctrl
// sequencer for the conversion phases and the result handshake
// ---------------------------------------------------------------------------
`include "epoch_seconds_to_calendar_date_macros.svh"

module esc_ctrl
   import esc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd,
   input  dp_sts_type sts
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DAYS  = 4'd1;
   localparam logic [3:0] ST_TOD   = 4'd2;
   localparam logic [3:0] ST_HOUR  = 4'd3;
   localparam logic [3:0] ST_REMH  = 4'd4;
   localparam logic [3:0] ST_MIN   = 4'd5;
   localparam logic [3:0] ST_SEC   = 4'd6;
   localparam logic [3:0] ST_YEAR  = 4'd7;
   localparam logic [3:0] ST_MONTH = 4'd8;
   localparam logic [3:0] ST_DONE  = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.load = LD_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = LD_SECS;
               state_in = ST_DAYS;
            end
         end
         ST_DAYS: begin
            cmd.load = LD_DAYS;
            state_in = ST_TOD;
         end
         ST_TOD: begin
            cmd.load = LD_TOD;
            state_in = ST_HOUR;
         end
         ST_HOUR: begin
            cmd.load = LD_HOUR;
            state_in = ST_REMH;
         end
         ST_REMH: begin
            cmd.load = LD_REMH;
            state_in = ST_MIN;
         end
         ST_MIN: begin
            cmd.load = LD_MIN;
            state_in = ST_SEC;
         end
         ST_SEC: begin
            cmd.load = LD_SEC;
            state_in = ST_YEAR;
         end
         ST_YEAR: begin
            if (sts.year_fit) begin
               cmd.load = LD_MONTH;
               state_in = ST_MONTH;
            end else begin
               cmd.year_step = 1'b1;
            end
         end
         ST_MONTH: begin
            if (sts.month_fit) begin
               state_in = ST_DONE;
            end else begin
               cmd.month_step = 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ESC_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.out_load, !rsp_valid_ff || rsp_ready, "result overwritten")
   `ESC_ASSERT_NXT(a_taken_clears, clock, reset, rsp_valid_ff && rsp_ready && !cmd.out_load, !rsp_valid_ff, "taken result still shown")
   `ESC_ASSERT_NXT(a_accept_starts, clock, reset, req_valid && req_ready, state_ff == ST_DAYS, "accept did not start")

endmodule

@@ hdl/epoch_seconds_to_calendar_date.sv @@
// ---------------------------------------------------------------------------
// epoch_seconds_to_calendar_date
// seconds since 1970-01-01 00:00:00 to broken-down utc calendar time
// ---------------------------------------------------------------------------
// usage
//   req channel carries one 31-bit seconds count per word (valid/ready)
//   rsp channel returns year, month 0-11, day 1-31, hour, minute, second
//   and weekday (0 sunday) per word, one result for every request
//   after accept, six steps split days, time of day and weekday by
//   reciprocal multiply and multiply-back subtraction; then the year
//   walker steps once per year past 1970 (0..68 steps) and the month
//   walker once per month (0..11 steps), each stopping when the day
//   count fits, and the done state loads the result register once the
//   output register is free; one conversion at a time, so a new word is
//   taken only after the previous result is loaded into the output
//   the result sits in an output register, so a new word is taken while a
//   finished result waits; a stalled receiver only blocks the next finish
//   reset clears only the sequencer and rsp_valid; datapath values are kept
// ---------------------------------------------------------------------------
module epoch_seconds_to_calendar_date
   import esc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [SECS_W-1:0] req_epoch_seconds,
   // result
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [10:0]       rsp_year,
   output logic [3:0]        rsp_month,
   output logic [4:0]        rsp_day_of_month,
   output logic [4:0]        rsp_hour,
   output logic [5:0]        rsp_minute,
   output logic [5:0]        rsp_second,
   output logic [2:0]        rsp_weekday
);

   // sequencer to datapath commands and status flags
   dp_cmd_type cmd;
   dp_sts_type sts;

   // phase sequencer and result handshake
   esc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // time split, year/month walkers and output register
   esc_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day_of_month  (rsp_day_of_month),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second),
      .rsp_weekday       (rsp_weekday)
   );

endmodule

@@ dv/epoch_seconds_to_calendar_date_test.sv @@
// ---------------------------------------------------------------------------
// epoch_seconds_to_calendar_date_test
// self-checking bench: directed and random request words in bursts against a
// stalling receiver, every result compared field by field with a local gmtime model
// ---------------------------------------------------------------------------
module epoch_seconds_to_calendar_date_test;

   import esc_pkg::SECS_W;

   // calendar arithmetic
   localparam int unsigned MINUTE_SECONDS = 60;
   localparam int unsigned HOUR_SECONDS   = 3600;
   localparam int unsigned DAY_SECONDS    = 86400;
   localparam int unsigned EPOCH_YEAR    = 1970;
   localparam int unsigned EPOCH_WEEKDAY = 4;   // 1970-01-01 was a thursday
   localparam int unsigned LAST_YEAR_IDX = 68;  // 2038 is the last year reached
   localparam longint     MAX_SECS      = 64'h7FFF_FFFF;
   localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30,
                                               31, 31, 30, 31, 30, 31};

   localparam int     RANDOM_WORDS  = 1800;
   localparam int     HOLD_OFF_AT   = 300;        // accepted words before the long stall
   localparam int     HOLD_OFF_LEN  = 700;        // cycles of receiver hold-off
   localparam int     DRAIN_CYCLES  = 160;        // past the worst conversion latency
   localparam longint TIMEOUT_UNITS = 64'd36_000_000;  // simulation time limit for the hang guard

   typedef struct packed {
      logic [10:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  weekday;
   } calendar_word_type;

   // dut ports, inputs known from time zero
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [SECS_W-1:0] req_epoch_seconds = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [10:0]       rsp_year;
   logic [3:0]        rsp_month;
   logic [4:0]        rsp_day_of_month;
   logic [4:0]        rsp_hour;
   logic [5:0]        rsp_minute;
   logic [5:0]        rsp_second;
   logic [2:0]        rsp_weekday;

   // bench state
   logic [SECS_W-1:0] pending_seconds [$];
   calendar_word_type expected_dates [$];
   int                words_total = 0;
   int                words_accepted = 0;
   int                error_count = 0;
   logic              req_fired = 1'b0;
   logic              hold_off = 1'b0;

   // sender burst/gap state
   int                burst_left = 0;
   int                gap_left = 0;

   // receiver stall state
   int                ready_mode = 0;
   int                mode_left = 0;
   logic [7:0]        ready_bits = 8'hFF;

   epoch_seconds_to_calendar_date dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day_of_month  (rsp_day_of_month),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second),
      .rsp_weekday       (rsp_weekday)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // calendar model
   // ------------------------------------------------------------------------

   // gregorian rule: every 4th year, but not centuries unless divisible by 400
   function automatic bit is_leap_year(input int unsigned yr);
      return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
   endfunction

   function automatic int unsigned year_length(input int unsigned yr);
      return is_leap_year(yr) ? 366 : 365;
   endfunction

   function automatic int unsigned month_length(input int unsigned yr, input int unsigned mon);
      return MONTH_DAYS[mon] + ((mon == 1 && is_leap_year(yr)) ? 1 : 0);
   endfunction

   // broken-down utc time for a seconds count
   function automatic calendar_word_type utc_date_of(input logic [SECS_W-1:0] secs);
      int unsigned       total;
      int unsigned       days_left;
      int unsigned       day_secs;
      int unsigned       yr;
      int unsigned       mon;
      calendar_word_type date;
      total = secs;
      days_left = total / DAY_SECONDS;
      day_secs = total % DAY_SECONDS;
      date.hour = 5'(day_secs / HOUR_SECONDS);
      date.minute = 6'((day_secs % HOUR_SECONDS) / MINUTE_SECONDS);
      date.second = 6'(day_secs % MINUTE_SECONDS);
      date.weekday = 3'((EPOCH_WEEKDAY + days_left) % 7);
      // strip whole years
      yr = EPOCH_YEAR;
      while (days_left >= year_length(yr)) begin
         days_left -= year_length(yr);
         yr++;
      end
      // then whole months, never past december
      mon = 0;
      while (mon < 11 && days_left >= month_length(yr, mon)) begin
         days_left -= month_length(yr, mon);
         mon++;
      end
      date.year = 11'(yr);
      date.month = 4'(mon);
      date.day_of_month = 5'(days_left + 1);
      return date;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   // clip to the legal 31-bit range and queue
   task automatic queue_seconds(input longint secs);
      if (secs < 0)
         secs = 0;
      if (secs > MAX_SECS)
         secs = MAX_SECS;
      pending_seconds.push_back(SECS_W'(secs));
   endtask

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
   endtask

   // ------------------------------------------------------------------------
   // driver: request words at the falling edge, bursts with random gaps
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fired) begin
         // word still on offer, hold it
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         req_valid <= 1'b0;
      end else if (pending_seconds.size() != 0) begin
         req_valid <= 1'b1;
         req_epoch_seconds <= pending_seconds.pop_front();
         if (burst_left <= 1) begin
            // end of burst: pick the next burst length and the idle gap
            burst_left <= $urandom_range(1, 40);
            case ($urandom_range(0, 9))
               0, 1, 2, 3: gap_left <= 0;
               4, 5, 6:    gap_left <= $urandom_range(1, 8);
               7, 8:       gap_left <= $urandom_range(9, 60);
               default:    gap_left <= $urandom_range(61, 180);
            endcase
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // receiver: ready pattern changes mode every so often
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= $urandom_range(0, 3);
         mode_left <= $urandom_range(50, 400);
         ready_bits <= 8'($urandom);
         rsp_ready <= !hold_off;
      end else begin
         mode_left <= mode_left - 1;
         ready_bits <= {ready_bits[0], ready_bits[7:1]};
         case (ready_mode)
            0:       rsp_ready <= !hold_off;                                // stalls only in hold-off
            1:       rsp_ready <= !hold_off && ($urandom_range(0, 1) == 0);
            2:       rsp_ready <= !hold_off && ($urandom_range(0, 7) == 0); // mostly stalled
            default: rsp_ready <= !hold_off && ready_bits[0];               // fixed rotation
         endcase
      end
   end

   // long receiver hold-off so the block fills and drops req_ready
   initial begin
      wait (words_accepted >= HOLD_OFF_AT);
      @(negedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_LEN) @(negedge clock);
      hold_off <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // monitor: sample both channels at the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      calendar_word_type want;
      req_fired <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_dates.size() == 0) begin
               report_mismatch($sformatf("result word %0d-%0d-%0d with nothing pending",
                                         rsp_year, rsp_month, rsp_day_of_month));
            end else begin
               want = expected_dates.pop_front();
               if (rsp_year !== want.year)
                  report_mismatch($sformatf("year %0d, want %0d", rsp_year, want.year));
               if (rsp_month !== want.month)
                  report_mismatch($sformatf("month %0d, want %0d", rsp_month, want.month));
               if (rsp_day_of_month !== want.day_of_month)
                  report_mismatch($sformatf("day_of_month %0d, want %0d",
                                            rsp_day_of_month, want.day_of_month));
               if (rsp_hour !== want.hour)
                  report_mismatch($sformatf("hour %0d, want %0d", rsp_hour, want.hour));
               if (rsp_minute !== want.minute)
                  report_mismatch($sformatf("minute %0d, want %0d", rsp_minute, want.minute));
               if (rsp_second !== want.second)
                  report_mismatch($sformatf("second %0d, want %0d", rsp_second, want.second));
               if (rsp_weekday !== want.weekday)
                  report_mismatch($sformatf("weekday %0d, want %0d",
                                            rsp_weekday, want.weekday));
            end
         end
         if (req_valid && req_ready) begin
            expected_dates.push_back(utc_date_of(req_epoch_seconds));
            words_accepted++;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      longint      year_start [0:LAST_YEAR_IDX];
      longint      day_start;
      int unsigned yr_idx;
      int unsigned mon;

      // first day of each year, in days since the epoch
      year_start[0] = 0;
      for (int i = 1; i <= LAST_YEAR_IDX; i++)
         year_start[i] = year_start[i-1] + year_length(EPOCH_YEAR + i - 1);

      // directed: field extremes, day/month/year rollovers, leap days
      queue_seconds(0);                    // the epoch itself
      queue_seconds(MAX_SECS);             // latest date, 2038-01-19
      queue_seconds(86399);                // last second of day zero
      queue_seconds(86400);                // first friday
      queue_seconds(2678399);              // jan 31 1970, end of a 31-day month
      queue_seconds(2678400);              // feb 1 1970
      queue_seconds(5097599);              // feb 28 1970, non-leap february end
      queue_seconds(5097600);              // mar 1 1970
      queue_seconds(31535999);             // dec 31 1970 23:59:59
      queue_seconds(31536000);             // jan 1 1971
      queue_seconds(68169600);             // feb 29 1972, leap day
      queue_seconds(94694399);             // dec 31 of a leap year, month walk runs out
      queue_seconds(946684799);            // dec 31 1999 23:59:59
      queue_seconds(946684800);            // 2000, century year that is leap
      queue_seconds(951868799);            // feb 29 2000 23:59:59
      queue_seconds(951868800);            // mar 1 2000
      queue_seconds(2114380799);           // dec 31 2036, last leap year end
      queue_seconds(2145916800);           // jan 1 2038
      queue_seconds(64'h4000_0000);        // only the top input bit
      queue_seconds(64'h5555_5555 & MAX_SECS);
      queue_seconds(64'h2AAA_AAAA);
      queue_seconds(86400 * 3 - 1);        // saturday 23:59:59

      // random: full range, year/month rollovers and day rollovers
      repeat (RANDOM_WORDS) begin
         case ($urandom_range(0, 3))
            0, 1: queue_seconds($urandom & 32'h7FFF_FFFF);
            2: begin
               yr_idx = $urandom_range(0, LAST_YEAR_IDX);
               mon = $urandom_range(0, 11);
               day_start = year_start[yr_idx];
               for (int m = 0; m < mon; m++)
                  day_start += month_length(EPOCH_YEAR + yr_idx, m);
               queue_seconds(day_start * DAY_SECONDS + longint'($urandom_range(0, 4)) - 2);
            end
            default: begin
               day_start = $urandom_range(0, 24855);
               queue_seconds(day_start * DAY_SECONDS + longint'($urandom_range(0, 2)) - 1
                             + (($urandom_range(0, 1) == 0) ? 0 : longint'($urandom_range(0, 86399))));
            end
         endcase
      end
      words_total = pending_seconds.size();

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // all words taken, every result back, then a quiet tail
      wait (words_accepted == words_total);
      while (expected_dates.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("epoch_seconds_to_calendar_date verification clean");
      else
         $display("epoch_seconds_to_calendar_date verification failed");
      $finish;
   end

   // hang guard
   initial begin
      #(TIMEOUT_UNITS);
      $display("epoch_seconds_to_calendar_date verification failed");
      $finish;
   end

endmodule
